// ===== rtl/touch_electrode_smoother_detector_defines.svh =====
// Assertion macros used by the top level of the touch electrode smoother and detector.
`ifndef TOUCH_ELECTRODE_SMOOTHER_DETECTOR_DEFINES_SVH
`define TOUCH_ELECTRODE_SMOOTHER_DETECTOR_DEFINES_SVH

// same-cycle implication
`define TESD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tesd: same-cycle check failed");

// next-cycle implication
`define TESD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tesd: next-cycle check failed");

`endif

// ===== rtl/tesd_pkg.sv =====
// Types and constants of the touch electrode smoother and detector.
package tesd_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int INDEX_BITS  = 4;
  localparam int WEIGHT_BITS = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 10;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SMOOTHING_WEIGHT  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_USE_BOARD_FLAG    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TOUCH_THRESHOLD   = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE_THRESHOLD = 2'd3;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET          = 8'd0;
  localparam logic [SAMPLE_BITS-1:0] TOUCH_THRESHOLD_RESET   = 10'd160;
  localparam logic [SAMPLE_BITS-1:0] RELEASE_THRESHOLD_RESET = 10'd80;

  typedef struct packed {
    logic [INDEX_BITS-1:0]  electrode_index;
    logic                   board_touch;
    logic [SAMPLE_BITS-1:0] raw_diff;
    logic [SAMPLE_BITS-1:0] raw_baseline;
    logic [SAMPLE_BITS-1:0] raw_filtered;
  } sample_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]  out_electrode;
    logic [SAMPLE_BITS-1:0] smoothed_diff;
    logic [SAMPLE_BITS-1:0] smoothed_baseline;
    logic [SAMPLE_BITS-1:0] smoothed_filtered;
    logic                   touched;
    logic                   touch_event;
    logic                   release_event;
  } result_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] smoothing_weight;
    logic                   use_board_flag;
    logic [SAMPLE_BITS-1:0] touch_threshold;
    logic [SAMPLE_BITS-1:0] release_threshold;
  } cfg_regs_t;

endpackage

// ===== rtl/tesd_cfg.sv =====
// Configuration register file of the touch electrode smoother and detector.
module tesd_cfg
  import tesd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_regs_t                 regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.smoothing_weight  <= WEIGHT_RESET;
      regs.use_board_flag    <= 1'b1;
      regs.touch_threshold   <= TOUCH_THRESHOLD_RESET;
      regs.release_threshold <= RELEASE_THRESHOLD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SMOOTHING_WEIGHT:  regs.smoothing_weight  <= cfg_data[WEIGHT_BITS-1:0];
        CFG_USE_BOARD_FLAG:    regs.use_board_flag    <= cfg_data[0];
        CFG_TOUCH_THRESHOLD:   regs.touch_threshold   <= cfg_data[SAMPLE_BITS-1:0];
        CFG_RELEASE_THRESHOLD: regs.release_threshold <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/tesd_blend.sv =====
// Exponential smoothing of one reading: raw + w*(old-raw)/256 form of the blend.
module tesd_blend
  import tesd_pkg::*;
(
  input  logic [WEIGHT_BITS-1:0] weight,
  input  logic [SAMPLE_BITS-1:0] raw,
  input  logic [SAMPLE_BITS-1:0] old,
  output logic [SAMPLE_BITS-1:0] blended
);

  localparam int SUM_BITS = SAMPLE_BITS + WEIGHT_BITS + 2;

  logic signed [SAMPLE_BITS:0]  delta;
  logic signed [SUM_BITS-1:0]   prod;
  logic signed [SUM_BITS-1:0]   sum;

  always_comb begin
    delta = $signed({1'b0, old}) - $signed({1'b0, raw});
    prod  = $signed({{(SUM_BITS-WEIGHT_BITS){1'b0}}, weight})
          * $signed({{(SUM_BITS-SAMPLE_BITS-1){delta[SAMPLE_BITS]}}, delta});
    sum   = $signed({2'b00, raw, {WEIGHT_BITS{1'b0}}}) + prod;
  end

  assign blended = sum[SAMPLE_BITS+WEIGHT_BITS-1:WEIGHT_BITS];

endmodule

// ===== rtl/touch_electrode_smoother_detector.sv =====
// Top level of the touch electrode smoother and detector.
// Takes one electrode sample per clock while the result sink keeps up, and returns
// one result beat per sample, registered first in the input register and then in
// the result register. Throughput is one sample per cycle when the sink is free: the
// per-electrode smoothing stores and status bits are read, blended and written back
// within the single stage between the two registers, so consecutive samples of the
// same electrode need no forwarding. Configuration is taken in any cycle; write it
// only while the block is idle. Samples whose electrode index is not below
// ELECTRODE_COUNT leave all state untouched and return zero fields apart from the
// echoed index.
`include "touch_electrode_smoother_detector_defines.svh"
module touch_electrode_smoother_detector
  import tesd_pkg::*;
#(
  parameter int ELECTRODE_COUNT = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_ready,
  input  sample_t                   sample,
  output logic                      result_valid,
  input  logic                      result_ready,
  output result_t                   result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int IDX_W = (ELECTRODE_COUNT > 1) ? $clog2(ELECTRODE_COUNT) : 1;

  cfg_regs_t regs;

  logic    hold_valid;
  sample_t hold;
  logic    advance;

  logic [SAMPLE_BITS-1:0] diff_store     [ELECTRODE_COUNT];
  logic [SAMPLE_BITS-1:0] baseline_store [ELECTRODE_COUNT];
  logic [SAMPLE_BITS-1:0] filtered_store [ELECTRODE_COUNT];
  logic [ELECTRODE_COUNT-1:0] status_bits;

  logic [31:0]            idx_wide;
  logic [IDX_W-1:0]       sel;
  logic                   in_range;
  logic [SAMPLE_BITS-1:0] diff_next;
  logic [SAMPLE_BITS-1:0] baseline_next;
  logic [SAMPLE_BITS-1:0] filtered_next;
  logic                   was;
  logic                   tev;
  logic                   rev;
  logic                   status_next;
  result_t                result_next;

  tesd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  assign advance      = hold_valid && (!result_valid || result_ready);
  assign sample_ready = !hold_valid || advance;

  assign idx_wide = 32'(hold.electrode_index);
  assign sel      = idx_wide[IDX_W-1:0];
  assign in_range = idx_wide < 32'(ELECTRODE_COUNT);

  tesd_blend u_blend_diff (
    .weight  (regs.smoothing_weight),
    .raw     (hold.raw_diff),
    .old     (diff_store[sel]),
    .blended (diff_next)
  );

  tesd_blend u_blend_baseline (
    .weight  (regs.smoothing_weight),
    .raw     (hold.raw_baseline),
    .old     (baseline_store[sel]),
    .blended (baseline_next)
  );

  tesd_blend u_blend_filtered (
    .weight  (regs.smoothing_weight),
    .raw     (hold.raw_filtered),
    .old     (filtered_store[sel]),
    .blended (filtered_next)
  );

  always_comb begin
    was = status_bits[sel];
    if (regs.use_board_flag) begin
      tev = hold.board_touch && !was;
      rev = !hold.board_touch && was;
    end else begin
      tev = (diff_next > regs.touch_threshold) && !was;
      rev = (diff_next < regs.release_threshold) && was;
    end
    status_next = tev || (was && !rev);

    result_next = '0;
    result_next.out_electrode = hold.electrode_index;
    if (in_range) begin
      result_next.smoothed_diff     = diff_next;
      result_next.smoothed_baseline = baseline_next;
      result_next.smoothed_filtered = filtered_next;
      result_next.touched           = status_next;
      result_next.touch_event       = tev;
      result_next.release_event     = rev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
      status_bits  <= '0;
      for (int i = 0; i < ELECTRODE_COUNT; i++) begin
        diff_store[i]     <= '0;
        baseline_store[i] <= '0;
        filtered_store[i] <= '0;
      end
    end else begin
      if (sample_valid && sample_ready) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (advance && in_range) begin
        diff_store[sel]     <= diff_next;
        baseline_store[sel] <= baseline_next;
        filtered_store[sel] <= filtered_next;
        status_bits[sel]    <= status_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      hold <= sample;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  `TESD_ASSERT_NOW(a_one_event, clk, rst, result_valid,
                   !(result.touch_event && result.release_event))
  `TESD_ASSERT_NOW(a_touch_sets_status, clk, rst, result_valid && result.touch_event,
                   result.touched)
  `TESD_ASSERT_NOW(a_release_clears_status, clk, rst, result_valid && result.release_event,
                   !result.touched)
  `TESD_ASSERT_NEXT(a_accept_fills_hold, clk, rst, sample_valid && sample_ready,
                    hold_valid)

endmodule
